FILE: design/lspd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lspd_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int GAIN_W       = 8;
  localparam int SPEED_IN_W   = 8;
  localparam int THR_W        = 10;
  localparam int DUTY_W       = 8;
  localparam int POS_W        = 6;
  // |weighted sum| / sum never exceeds the outer weight, so four quotient bits do
  localparam int QUOT_BITS    = 4;
  localparam int PROD_W       = 16;
  localparam int SPEED_W      = 19;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(512);

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_THR  = 2'd3;

  localparam int SENSOR_WEIGHT [SENSOR_COUNT] = '{10, 7, 4, 1, -1, -4, -7, -10};

  typedef struct packed {
    logic [GAIN_W-1:0]     prop_gain;
    logic [GAIN_W-1:0]     deriv_gain;
    logic [SPEED_IN_W-1:0] base_speed;
    logic [THR_W-1:0]      black_threshold;
  } cfg_t;

endpackage
`default_nettype wire

FILE: design/lspd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lspd_in_if #(
  parameter int SENSOR_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SENSOR_BITS-1:0] sensor_0;
  logic [SENSOR_BITS-1:0] sensor_1;
  logic [SENSOR_BITS-1:0] sensor_2;
  logic [SENSOR_BITS-1:0] sensor_3;
  logic [SENSOR_BITS-1:0] sensor_4;
  logic [SENSOR_BITS-1:0] sensor_5;
  logic [SENSOR_BITS-1:0] sensor_6;
  logic [SENSOR_BITS-1:0] sensor_7;

  modport source (output valid, sensor_0, sensor_1, sensor_2, sensor_3,
                  sensor_4, sensor_5, sensor_6, sensor_7, input ready);
  modport sink   (input valid, sensor_0, sensor_1, sensor_2, sensor_3,
                  sensor_4, sensor_5, sensor_6, sensor_7, output ready);
endinterface

interface lspd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [lspd_pkg::DUTY_W-1:0]          left_duty;
  logic                                 left_reverse;
  logic [lspd_pkg::DUTY_W-1:0]          right_duty;
  logic                                 right_reverse;
  logic signed [lspd_pkg::POS_W-1:0]    line_position;
  logic                                 all_black;

  modport source (output valid, left_duty, left_reverse, right_duty, right_reverse,
                  line_position, all_black, input ready);
  modport sink   (input valid, left_duty, left_reverse, right_duty, right_reverse,
                  line_position, all_black, output ready);
endinterface
`default_nettype wire

FILE: design/lspd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lspd_front #(
  parameter int SENSOR_BITS = 10,
  localparam int SUM_W = SENSOR_BITS + 3,
  localparam int WS_W  = SENSOR_BITS + 6,
  localparam int MAG_W = SENSOR_BITS + 5
) (
  input  wire logic [lspd_pkg::SENSOR_COUNT-1:0][SENSOR_BITS-1:0] sensors,
  input  wire logic [lspd_pkg::THR_W-1:0]                         threshold,
  output logic [SUM_W-1:0]                                        sum,
  output logic [MAG_W-1:0]                                        wsum_mag,
  output logic                                                    wsum_neg,
  output logic                                                    sum_zero,
  output logic                                                    black
);

  localparam int TW = (SENSOR_BITS > lspd_pkg::THR_W) ? SENSOR_BITS : lspd_pkg::THR_W;

  logic signed [WS_W-1:0] wsum;
  logic signed [WS_W-1:0] wsum_abs;

  always_comb begin
    logic signed [WS_W-1:0] term;
    sum   = '0;
    wsum  = '0;
    black = 1'b1;
    for (int i = 0; i < lspd_pkg::SENSOR_COUNT; i++) begin
      term  = signed'(WS_W'(sensors[i]));
      sum   = sum + SUM_W'(sensors[i]);
      wsum  = wsum + WS_W'(lspd_pkg::SENSOR_WEIGHT[i]) * term;
      if (TW'(sensors[i]) < TW'(threshold)) begin
        black = 1'b0;
      end
    end
  end

  assign wsum_neg = wsum[WS_W-1];
  assign wsum_abs = wsum_neg ? -wsum : wsum;
  assign wsum_mag = wsum_abs[MAG_W-1:0];
  assign sum_zero = (sum == '0);

endmodule
`default_nettype wire

FILE: design/lspd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module lspd_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              pop_valid,
  output logic [W-1:0]      pop_data
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: design/lspd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lspd_back #(
  parameter int SENSOR_BITS = 10,
  parameter int DUTY_MAX    = 255,
  localparam int SUM_W = SENSOR_BITS + 3,
  localparam int MAG_W = SENSOR_BITS + 5,
  localparam int SH_W  = SUM_W + 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lspd_pkg::cfg_t   cfg,
  input  wire logic             q_valid,
  input  wire logic [SUM_W-1:0] q_sum,
  input  wire logic [MAG_W-1:0] q_mag,
  input  wire logic             q_neg,
  input  wire logic             q_zero,
  input  wire logic             q_black,
  output logic                  q_pop,
  lspd_out_if.source            out
);

  typedef enum logic [1:0] {IDLE, DIV, MUL, FIN} state_t;

  localparam logic signed [lspd_pkg::SPEED_W-1:0] DMAX = lspd_pkg::SPEED_W'(DUTY_MAX);

  state_t                               state_r;
  logic [MAG_W-1:0]                     rem_r;
  logic [SUM_W-1:0]                     den_r;
  logic [lspd_pkg::QUOT_BITS-1:0]       quot_r;
  logic [1:0]                           step_r;
  logic                                 neg_r;
  logic                                 zero_r;
  logic                                 black_r;
  logic signed [lspd_pkg::POS_W-1:0]    pos_r;
  logic signed [lspd_pkg::POS_W-1:0]    prev_err_r;
  logic signed [lspd_pkg::PROD_W-1:0]   prod_p_r;
  logic signed [lspd_pkg::PROD_W-1:0]   prod_d_r;

  logic                                 out_valid_r;
  logic [lspd_pkg::DUTY_W-1:0]          left_duty_r;
  logic                                 left_rev_r;
  logic [lspd_pkg::DUTY_W-1:0]          right_duty_r;
  logic                                 right_rev_r;
  logic signed [lspd_pkg::POS_W-1:0]    line_pos_r;
  logic                                 all_black_r;

  // divider step
  logic [SH_W-1:0]                      den_sh;
  logic                                 fits;
  // position and PD products
  logic [lspd_pkg::POS_W-1:0]           pos_mag;
  logic signed [lspd_pkg::POS_W-1:0]    pos;
  logic signed [lspd_pkg::PROD_W-1:0]   pos_ext;
  logic signed [lspd_pkg::PROD_W-1:0]   diff_ext;
  logic signed [lspd_pkg::PROD_W-1:0]   pg_ext;
  logic signed [lspd_pkg::PROD_W-1:0]   dg_ext;
  // speeds
  logic signed [lspd_pkg::SPEED_W-1:0]  corr;
  logic signed [lspd_pkg::SPEED_W-1:0]  base_ext;
  logic signed [lspd_pkg::SPEED_W-1:0]  left_spd;
  logic signed [lspd_pkg::SPEED_W-1:0]  right_spd;
  logic signed [lspd_pkg::SPEED_W-1:0]  left_cl;
  logic signed [lspd_pkg::SPEED_W-1:0]  right_cl;
  logic signed [lspd_pkg::SPEED_W-1:0]  left_abs;
  logic signed [lspd_pkg::SPEED_W-1:0]  right_abs;
  logic                                 out_free;

  assign den_sh = SH_W'(den_r) << step_r;
  assign fits   = (SH_W'(rem_r) >= den_sh);

  assign pos_mag  = {1'b0, quot_r, 1'b0};
  assign pos      = zero_r ? '0 : (neg_r ? -signed'(pos_mag) : signed'(pos_mag));
  assign pos_ext  = lspd_pkg::PROD_W'(pos);
  assign diff_ext = pos_ext - lspd_pkg::PROD_W'(prev_err_r);
  assign pg_ext   = signed'(lspd_pkg::PROD_W'(cfg.prop_gain));
  assign dg_ext   = signed'(lspd_pkg::PROD_W'(cfg.deriv_gain));

  assign corr      = lspd_pkg::SPEED_W'(prod_p_r) + lspd_pkg::SPEED_W'(prod_d_r);
  assign base_ext  = signed'(lspd_pkg::SPEED_W'(cfg.base_speed));
  assign left_spd  = base_ext - corr;
  assign right_spd = base_ext + corr;

  always_comb begin
    priority if (left_spd > DMAX)  left_cl = DMAX;
    else if (left_spd < -DMAX)     left_cl = -DMAX;
    else                           left_cl = left_spd;
    priority if (right_spd > DMAX) right_cl = DMAX;
    else if (right_spd < -DMAX)    right_cl = -DMAX;
    else                           right_cl = right_spd;
  end

  assign left_abs  = left_cl[lspd_pkg::SPEED_W-1]  ? -left_cl  : left_cl;
  assign right_abs = right_cl[lspd_pkg::SPEED_W-1] ? -right_cl : right_cl;

  assign out_free = !out_valid_r || out.ready;
  assign q_pop    = (state_r == IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (q_valid) begin
            rem_r   <= q_mag;
            den_r   <= q_sum;
            neg_r   <= q_neg;
            zero_r  <= q_zero;
            black_r <= q_black;
            quot_r  <= '0;
            step_r  <= 2'(lspd_pkg::QUOT_BITS - 1);
            state_r <= DIV;
          end
        end
        DIV: begin
          // restoring division, one quotient bit a cycle, msb first
          if (fits) begin
            rem_r          <= MAG_W'(SH_W'(rem_r) - den_sh);
            quot_r[step_r] <= 1'b1;
          end
          if (step_r == 2'd0) begin
            state_r <= MUL;
          end
          step_r <= step_r - 2'd1;
        end
        MUL: begin
          pos_r    <= pos;
          prod_p_r <= pg_ext * pos_ext;
          prod_d_r <= dg_ext * diff_ext;
          state_r  <= FIN;
        end
        FIN: begin
          if (out_free) begin
            left_duty_r  <= left_abs[lspd_pkg::DUTY_W-1:0];
            left_rev_r   <= left_cl[lspd_pkg::SPEED_W-1];
            right_duty_r <= right_abs[lspd_pkg::DUTY_W-1:0];
            right_rev_r  <= right_cl[lspd_pkg::SPEED_W-1];
            line_pos_r   <= pos_r;
            all_black_r  <= black_r;
            prev_err_r   <= pos_r;
            state_r      <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out.valid         = out_valid_r;
  assign out.left_duty     = left_duty_r;
  assign out.left_reverse  = left_rev_r;
  assign out.right_duty    = right_duty_r;
  assign out.right_reverse = right_rev_r;
  assign out.line_position = line_pos_r;
  assign out.all_black     = all_black_r;

endmodule
`default_nettype wire

FILE: design/line_sensor_pd_steering_top.sv
`timescale 1ns / 1ps
`default_nettype none
// PD steering for a line follower with eight reflectance sensors. Each input beat
// carries eight readings; the front end forms the reading sum, the weighted sum and
// the all-black flag in the cycle the beat is taken and parks them in a two-entry
// queue. The back end divides with a four-step restoring divider, forms the PD
// correction and drives one result beat with both wheel duties, reverse flags and
// the line position. The back end holds one item at a time through its load, the
// four divider steps, the multiply and the registering of the result, so it takes
// no new item before the last is out; the queue lets up to two further beats be
// taken while the back end is busy or the result is stalled. Registers are written
// through cfg_we / cfg_idx / cfg_data: 0 prop_gain, 1 deriv_gain, 2 base_speed,
// 3 black_threshold (reset 512); write them only while the block is idle.
module line_sensor_pd_steering_top #(
  parameter int SENSOR_BITS = 10,
  parameter int DUTY_MAX    = 255
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lspd_in_if.sink                                in_ch,
  lspd_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [lspd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [lspd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SUM_W = SENSOR_BITS + 3;
  localparam int MAG_W = SENSOR_BITS + 5;
  localparam int Q_W   = SUM_W + MAG_W + 3;

  lspd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain       <= '0;
      cfg_r.deriv_gain      <= '0;
      cfg_r.base_speed      <= '0;
      cfg_r.black_threshold <= lspd_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lspd_pkg::REG_PROP_GAIN:  cfg_r.prop_gain       <= cfg_data[lspd_pkg::GAIN_W-1:0];
        lspd_pkg::REG_DERIV_GAIN: cfg_r.deriv_gain      <= cfg_data[lspd_pkg::GAIN_W-1:0];
        lspd_pkg::REG_BASE_SPEED: cfg_r.base_speed      <= cfg_data[lspd_pkg::SPEED_IN_W-1:0];
        lspd_pkg::REG_BLACK_THR:  cfg_r.black_threshold <= cfg_data[lspd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [lspd_pkg::SENSOR_COUNT-1:0][SENSOR_BITS-1:0] sensors;
  logic [SUM_W-1:0] f_sum;
  logic [MAG_W-1:0] f_mag;
  logic             f_neg;
  logic             f_zero;
  logic             f_black;
  logic             q_full;
  logic             push;
  logic             q_valid;
  logic             q_pop;
  logic [Q_W-1:0]   q_data;

  assign sensors = {in_ch.sensor_7, in_ch.sensor_6, in_ch.sensor_5, in_ch.sensor_4,
                    in_ch.sensor_3, in_ch.sensor_2, in_ch.sensor_1, in_ch.sensor_0};

  lspd_front #(.SENSOR_BITS(SENSOR_BITS)) u_front (
    .sensors   (sensors),
    .threshold (cfg_r.black_threshold),
    .sum       (f_sum),
    .wsum_mag  (f_mag),
    .wsum_neg  (f_neg),
    .sum_zero  (f_zero),
    .black     (f_black)
  );

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  lspd_fifo #(.W(Q_W)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_neg, f_zero, f_black, f_mag, f_sum}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  lspd_back #(.SENSOR_BITS(SENSOR_BITS), .DUTY_MAX(DUTY_MAX)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_sum   (q_data[SUM_W-1:0]),
    .q_mag   (q_data[SUM_W +: MAG_W]),
    .q_black (q_data[SUM_W+MAG_W]),
    .q_zero  (q_data[SUM_W+MAG_W+1]),
    .q_neg   (q_data[SUM_W+MAG_W+2]),
    .q_pop   (q_pop),
    .out     (out_ch)
  );

endmodule
`default_nettype wire

FILE: design/lspd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lspd_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [lspd_pkg::POS_W-1:0]    out_line_position,
  input wire logic [lspd_pkg::DUTY_W-1:0]          out_left_duty
);

  // a held result keeps its payload until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_position)
                                && $stable(out_left_duty))
    else $error("result changed while stalled");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_position <= 6'sd20) && (out_line_position >= -6'sd20))
    else $error("line position out of range");

  // position is a doubled quotient
  a_pos_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_line_position[0])
    else $error("line position odd");

  a_reset_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result beat straight after reset");

endmodule

bind line_sensor_pd_steering_top lspd_checker u_lspd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_line_position (out_ch.line_position),
  .out_left_duty     (out_ch.left_duty)
);
`default_nettype wire

FILE: verif/tb_line_sensor_pd_steering_top.sv
`timescale 1ns / 1ps
module tb_line_sensor_pd_steering_top;

  localparam int SENSOR_BITS = 10;
  localparam int SENSOR_MAX  = (1 << SENSOR_BITS) - 1;
  localparam int DUTY_LIMIT  = 255;
  localparam int STALL_LIMIT = 4000;
  localparam int LANE_WEIGHT [8] = '{10, 7, 4, 1, -1, -4, -7, -10};

  typedef logic [SENSOR_BITS-1:0] readings_t [8];

  typedef struct packed {
    logic [lspd_pkg::DUTY_W-1:0]       left_duty;
    logic                              left_reverse;
    logic [lspd_pkg::DUTY_W-1:0]       right_duty;
    logic                              right_reverse;
    logic signed [lspd_pkg::POS_W-1:0] line_position;
    logic                              all_black;
  } steer_result_t;

  class steering_scoreboard;
    int prop_gain;
    int deriv_gain;
    int base_speed;
    int black_thr;
    int last_error;
    int failures;
    steer_result_t steer_q[$];

    function new();
      prop_gain  = 0;
      deriv_gain = 0;
      base_speed = 0;
      black_thr  = 512;
      last_error = 0;
      failures   = 0;
    endfunction

    function void write_reg(logic [lspd_pkg::CFG_IDX_W-1:0] idx,
                            logic [lspd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        lspd_pkg::REG_PROP_GAIN:  prop_gain  = int'(data[lspd_pkg::GAIN_W-1:0]);
        lspd_pkg::REG_DERIV_GAIN: deriv_gain = int'(data[lspd_pkg::GAIN_W-1:0]);
        lspd_pkg::REG_BASE_SPEED: base_speed = int'(data[lspd_pkg::SPEED_IN_W-1:0]);
        lspd_pkg::REG_BLACK_THR:  black_thr  = int'(data[lspd_pkg::THR_W-1:0]);
        default: ;
      endcase
    endfunction

    function void wheel(int speed, output logic [lspd_pkg::DUTY_W-1:0] duty,
                        output logic reverse);
      int s;
      s = speed;
      if (s > DUTY_LIMIT) s = DUTY_LIMIT;
      else if (s < -DUTY_LIMIT) s = -DUTY_LIMIT;
      reverse = (s < 0);
      duty    = (s < 0) ? lspd_pkg::DUTY_W'(-s) : lspd_pkg::DUTY_W'(s);
    endfunction

    function void note_frame(readings_t rd);
      int total;
      int weighted;
      int position;
      int corr;
      bit black;
      steer_result_t e;
      total    = 0;
      weighted = 0;
      black    = 1'b1;
      foreach (rd[i]) begin
        total    += int'(rd[i]);
        weighted += LANE_WEIGHT[i] * int'(rd[i]);
        if (int'(rd[i]) < black_thr) black = 1'b0;
      end
      // int division truncates toward zero
      position = (total != 0) ? (weighted / total) * 2 : 0;
      corr = prop_gain * position + deriv_gain * (position - last_error);
      wheel(base_speed - corr, e.left_duty, e.left_reverse);
      wheel(base_speed + corr, e.right_duty, e.right_reverse);
      e.line_position = lspd_pkg::POS_W'(position);
      e.all_black     = black;
      last_error      = position;
      steer_q.push_back(e);
    endfunction

    function void report(string field, int want, int seen);
      if (want != seen) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, seen);
        failures++;
      end
    endfunction

    function void check_result(steer_result_t got);
      steer_result_t e;
      if (steer_q.size() == 0) begin
        $display("%0t: result beat with no frame pending: expected none, actual %p",
                 $time, got);
        failures++;
        return;
      end
      e = steer_q.pop_front();
      report("left_duty", e.left_duty, got.left_duty);
      report("left_reverse", e.left_reverse, got.left_reverse);
      report("right_duty", e.right_duty, got.right_duty);
      report("right_reverse", e.right_reverse, got.right_reverse);
      report("line_position", e.line_position, got.line_position);
      report("all_black", e.all_black, got.all_black);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [lspd_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [lspd_pkg::CFG_DATA_W-1:0] cfg_data;
  bit                              calm;
  int                              idle_cycles;
  steering_scoreboard              sb;

  lspd_in_if #(.SENSOR_BITS(SENSOR_BITS)) in_ch ();
  lspd_out_if out_ch ();

  line_sensor_pd_steering_top #(
    .SENSOR_BITS(SENSOR_BITS),
    .DUTY_MAX   (DUTY_LIMIT)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // monitors and stall watchdog
  always @(posedge clk) begin : watch
    readings_t     rd;
    steer_result_t res;
    if (rst_n) begin
      idle_cycles++;
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        rd = '{in_ch.sensor_0, in_ch.sensor_1, in_ch.sensor_2, in_ch.sensor_3,
               in_ch.sensor_4, in_ch.sensor_5, in_ch.sensor_6, in_ch.sensor_7};
        sb.note_frame(rd);
        idle_cycles = 0;
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        res = '{out_ch.left_duty, out_ch.left_reverse, out_ch.right_duty,
                out_ch.right_reverse, out_ch.line_position, out_ch.all_black};
        sb.check_result(res);
        idle_cycles = 0;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_line_sensor_pd_steering_top: FAIL");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // called just after a rising edge; returns at the edge the beat is taken
  task automatic drive_frame(readings_t rd);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sensor_0 <= rd[0];
    in_ch.sensor_1 <= rd[1];
    in_ch.sensor_2 <= rd[2];
    in_ch.sensor_3 <= rd[3];
    in_ch.sensor_4 <= rd[4];
    in_ch.sensor_5 <= rd[5];
    in_ch.sensor_6 <= rd[6];
    in_ch.sensor_7 <= rd[7];
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.steer_q.size() != 0) @(posedge clk);
    // the queue and the back end hold up to three frames between them
    repeat (25) @(posedge clk);
  endtask

  task automatic set_reg(logic [lspd_pkg::CFG_IDX_W-1:0] idx,
                         logic [lspd_pkg::CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // upper bits of the 8-bit registers are junk and must be dropped
  task automatic apply_setting(int p, int d, int b, int t);
    set_reg(lspd_pkg::REG_PROP_GAIN,  {2'($urandom), 8'(p)});
    set_reg(lspd_pkg::REG_DERIV_GAIN, {2'($urandom), 8'(d)});
    set_reg(lspd_pkg::REG_BASE_SPEED, {2'($urandom), 8'(b)});
    set_reg(lspd_pkg::REG_BLACK_THR,  10'(t));
    cfg_we <= 1'b0;
  endtask

  function automatic readings_t random_frame();
    readings_t rd;
    int kind;
    int centre;
    int peak;
    int floor_lvl;
    int v;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // a line under one or two sensors over a dim floor
      floor_lvl = $urandom_range(0, 1) ? $urandom_range(0, 60) : 0;
      foreach (rd[i]) rd[i] = SENSOR_BITS'($urandom_range(0, floor_lvl));
      centre = $urandom_range(0, 7);
      peak   = $urandom_range(200, SENSOR_MAX);
      rd[centre] = SENSOR_BITS'(peak);
      if (centre < 7 && $urandom_range(0, 1))
        rd[centre+1] = SENSOR_BITS'($urandom_range(100, peak));
    end else if (kind < 80) begin
      foreach (rd[i]) rd[i] = SENSOR_BITS'($urandom);
    end else if (kind < 88) begin
      foreach (rd[i]) rd[i] = '0;
      if ($urandom_range(0, 1)) rd[$urandom_range(0, 7)] = SENSOR_BITS'($urandom_range(1, 3));
    end else begin
      // straddle the black threshold
      foreach (rd[i]) begin
        v = sb.black_thr + $urandom_range(0, 4) - 2;
        v = (v < 0) ? 0 : (v > SENSOR_MAX) ? SENSOR_MAX : v;
        rd[i] = SENSOR_BITS'(v);
      end
    end
    return rd;
  endfunction

  task automatic run_random(int count);
    repeat (count) drive_frame(random_frame());
  endtask

  initial begin
    sb          = new();
    calm        = 1'b0;
    idle_cycles = 0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= lspd_pkg::REG_PROP_GAIN;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.sensor_0 <= '0;
    in_ch.sensor_1 <= '0;
    in_ch.sensor_2 <= '0;
    in_ch.sensor_3 <= '0;
    in_ch.sensor_4 <= '0;
    in_ch.sensor_5 <= '0;
    in_ch.sensor_6 <= '0;
    in_ch.sensor_7 <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero gains, threshold 512
    drive_frame('{0, 0, 0, 0, 0, 0, 0, 0});
    drive_frame('{1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023});
    drain();

    apply_setting(12, 5, 150, 512);
    drive_frame('{1023, 0, 0, 0, 0, 0, 0, 0});
    drive_frame('{0, 0, 0, 0, 0, 0, 0, 1023});
    drive_frame('{0, 0, 0, 1, 0, 0, 0, 0});
    drive_frame('{0, 0, 0, 0, 5, 0, 0, 0});
    drive_frame('{1, 0, 0, 0, 0, 0, 0, 2});     // negative quotient truncates up
    drive_frame('{0, 3, 0, 0, 0, 0, 1, 0});
    drive_frame('{512, 512, 512, 512, 512, 512, 512, 512});
    drive_frame('{512, 512, 512, 512, 512, 511, 512, 512});
    drive_frame('{511, 511, 511, 511, 511, 511, 511, 511});
    drive_frame('{0, 0, 0, 0, 0, 0, 0, 0});
    drain();

    // full-scale swing saturates both wheels
    apply_setting(255, 255, 255, 1023);
    drive_frame('{1023, 0, 0, 0, 0, 0, 0, 0});
    drive_frame('{0, 0, 0, 0, 0, 0, 0, 1023});
    drive_frame('{1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023});
    drive_frame('{1023, 1023, 1022, 1023, 1023, 1023, 1023, 1023});
    drain();

    apply_setting(255, 255, 0, 0);
    drive_frame('{1, 0, 0, 0, 0, 0, 0, 0});
    drive_frame('{0, 0, 0, 0, 0, 0, 0, 0});
    drive_frame('{0, 0, 0, 0, 0, 0, 1023, 0});
    drain();

    apply_setting($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(60, 200),
                  $urandom_range(200, 800));
    run_random(100);
    drain();
    apply_setting(255, 0, 255, 1023);
    run_random(100);
    drain();
    apply_setting(0, 255, 0, 0);
    run_random(100);
    drain();
    apply_setting($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 1023));
    run_random(100);
    drain();
    apply_setting($urandom_range(0, 10), $urandom_range(0, 10), $urandom_range(100, 255), 512);
    run_random(100);
    drain();

    // closing stretch at full rate on both sides
    calm = 1'b1;
    apply_setting($urandom_range(0, 30), $urandom_range(0, 30), $urandom_range(0, 255),
                  $urandom_range(0, 1023));
    run_random(100);
    drain();
    repeat (20) @(posedge clk);

    if (sb.failures == 0 && sb.steer_q.size() == 0)
      $display("tb_line_sensor_pd_steering_top: PASS");
    else
      $display("tb_line_sensor_pd_steering_top: FAIL");
    $finish;
  end

endmodule
